@@ src/clxr_pkg.sv @@
// Shared types, codes and helper functions for the C subset token lexer.
package clxr_pkg;

    // Default sizes and the depth of the result queue.
    localparam int MAX_TOKENS_DEF = 8192;
    localparam int MAX_DIGITS_DEF = 63;
    localparam int QUEUE_DEPTH    = 4;

    // Largest value a number token can carry.
    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    // Scanner modes.
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_IDENT   = 3'd1;
    localparam logic [2:0] MODE_NUMBER  = 3'd2;
    localparam logic [2:0] MODE_STRING  = 3'd3;
    localparam logic [2:0] MODE_ESCAPE  = 3'd4;
    localparam logic [2:0] MODE_SLASH   = 3'd5;
    localparam logic [2:0] MODE_COMMENT = 3'd6;
    localparam logic [2:0] MODE_ERROR   = 3'd7;

    // Result types.
    localparam logic [1:0] RT_TEXT  = 2'd0;
    localparam logic [1:0] RT_TOKEN = 2'd1;
    localparam logic [1:0] RT_ERROR = 2'd2;

    // Token kinds.
    localparam logic [3:0] KIND_EOF         = 4'd0;
    localparam logic [3:0] KIND_NAME        = 4'd1;
    localparam logic [3:0] KIND_NUM         = 4'd2;
    localparam logic [3:0] KIND_STR         = 4'd3;
    localparam logic [3:0] KIND_INT         = 4'd4;
    localparam logic [3:0] KIND_OPEN_PAREN  = 4'd5;
    localparam logic [3:0] KIND_CLOSE_PAREN = 4'd6;
    localparam logic [3:0] KIND_OPEN_BRACE  = 4'd7;
    localparam logic [3:0] KIND_CLOSE_BRACE = 4'd8;
    localparam logic [3:0] KIND_SEMI        = 4'd9;
    localparam logic [3:0] KIND_SEPARATOR   = 4'd10;
    localparam logic [3:0] KIND_RET         = 4'd11;

    // Error codes.
    localparam logic [1:0] ERR_UNTERMINATED = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED   = 2'd1;
    localparam logic [1:0] ERR_LONG_NUMBER  = 2'd2;
    localparam logic [1:0] ERR_TOO_MANY     = 2'd3;

    // Keyword match progress: how much of "int" or "return" has been seen.
    localparam logic [3:0] KW_NONE   = 4'd0;
    localparam logic [3:0] KW_I      = 4'd1;
    localparam logic [3:0] KW_IN     = 4'd2;
    localparam logic [3:0] KW_INT    = 4'd3;
    localparam logic [3:0] KW_R      = 4'd4;
    localparam logic [3:0] KW_RE     = 4'd5;
    localparam logic [3:0] KW_RET    = 4'd6;
    localparam logic [3:0] KW_RETU   = 4'd7;
    localparam logic [3:0] KW_RETUR  = 4'd8;
    localparam logic [3:0] KW_RETURN = 4'd9;

    // Source character codes.
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } char_word_t;

    typedef struct packed {
        logic [1:0]  result_type;
        logic [3:0]  token_kind;
        logic [30:0] number_value;
        logic [7:0]  text_char;
        logic [1:0]  error_code;
        logic [7:0]  bad_char;
        logic        last;
    } result_word_t;

    // Up to two results produced by one source byte.
    typedef struct packed {
        logic [1:0]   count;
        result_word_t first;
        result_word_t second;
    } step_out_t;

    // Outcome of lexing one byte from the idle mode.
    typedef struct packed {
        logic [2:0]   mode;
        logic [3:0]   kp;
        logic         start_num;
        logic         has;
        logic         tok_inc;
        result_word_t res;
    } idle_lex_t;

    function automatic result_word_t text_result(input logic [3:0] kind,
                                                 input logic [7:0] c);
        result_word_t r;
        r             = '0;
        r.result_type = RT_TEXT;
        r.token_kind  = kind;
        r.text_char   = c;
        return r;
    endfunction

    function automatic result_word_t token_result(input logic [3:0]  kind,
                                                  input logic [30:0] val);
        result_word_t r;
        r              = '0;
        r.result_type  = RT_TOKEN;
        r.token_kind   = kind;
        r.number_value = val;
        return r;
    endfunction

    function automatic result_word_t error_result(input logic [1:0] code,
                                                  input logic [7:0] bad);
        result_word_t r;
        r             = '0;
        r.result_type = RT_ERROR;
        r.error_code  = code;
        r.bad_char    = bad;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    // Advance the keyword match by one identifier character.
    function automatic logic [3:0] kw_next(input logic [3:0] kp, input logic [7:0] c);
        logic [3:0] r;
        r = KW_NONE;
        case (kp)
            KW_I:     r = (c == "n") ? KW_IN     : KW_NONE;
            KW_IN:    r = (c == "t") ? KW_INT    : KW_NONE;
            KW_R:     r = (c == "e") ? KW_RE     : KW_NONE;
            KW_RE:    r = (c == "t") ? KW_RET    : KW_NONE;
            KW_RET:   r = (c == "u") ? KW_RETU   : KW_NONE;
            KW_RETU:  r = (c == "r") ? KW_RETUR  : KW_NONE;
            KW_RETUR: r = (c == "n") ? KW_RETURN : KW_NONE;
            default:  r = KW_NONE;
        endcase
        return r;
    endfunction

    // Token kind of a single-character punctuator, or end of file if none.
    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        k = KIND_EOF;
        case (c)
            "(":     k = KIND_OPEN_PAREN;
            ")":     k = KIND_CLOSE_PAREN;
            "{":     k = KIND_OPEN_BRACE;
            "}":     k = KIND_CLOSE_BRACE;
            ";":     k = KIND_SEMI;
            ",":     k = KIND_SEPARATOR;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    // Lex one byte starting from the idle mode. The full flag says the token
    // budget is spent, so a punctuator raises the token limit error instead.
    function automatic idle_lex_t idle_lex(input logic [7:0] c, input logic full);
        idle_lex_t  r;
        logic [3:0] pk;
        r      = '0;
        r.mode = MODE_IDLE;
        r.kp   = KW_NONE;
        pk     = punct_kind(c);
        if (c inside {[CH_TAB:8'h0D], " "})
        begin
            r.mode = MODE_IDLE;
        end
        else if (c == "/")
        begin
            r.mode = MODE_SLASH;
        end
        else if (c == "\"")
        begin
            r.mode = MODE_STRING;
        end
        else if (is_alpha(c) || c == "_")
        begin
            r.mode = MODE_IDENT;
            r.kp   = (c == "i") ? KW_I : (c == "r") ? KW_R : KW_NONE;
            r.has  = 1'b1;
            r.res  = text_result(KIND_NAME, c);
        end
        else if (is_digit(c))
        begin
            r.mode      = MODE_NUMBER;
            r.start_num = 1'b1;
        end
        else if (pk != KIND_EOF)
        begin
            r.has = 1'b1;
            if (full)
            begin
                r.mode = MODE_ERROR;
                r.res  = error_result(ERR_TOO_MANY, 8'h00);
            end
            else
            begin
                r.tok_inc = 1'b1;
                r.res     = token_result(pk, 31'd0);
            end
        end
        else
        begin
            r.mode = MODE_ERROR;
            r.has  = 1'b1;
            r.res  = error_result(ERR_UNEXPECTED, c);
        end
        return r;
    endfunction

endpackage

@@ src/clxr_core.sv @@
// Scanner state and the combinational step that turns one byte into results.
module clxr_core #(
    parameter int MAX_TOKENS = clxr_pkg::MAX_TOKENS_DEF,
    parameter int MAX_DIGITS = clxr_pkg::MAX_DIGITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  clxr_pkg::char_word_t  word,
    output clxr_pkg::step_out_t   step
);

    localparam int TW = $clog2(MAX_TOKENS + 1);
    localparam int DW = $clog2(MAX_DIGITS + 1);

    logic [2:0]    mode_reg, mode_next;
    logic [3:0]    kp_reg, kp_next;
    logic [30:0]   acc_reg, acc_next;
    logic [DW-1:0] dc_reg, dc_next;
    logic [TW-1:0] tok_reg, tok_next;

    logic [7:0]    c;
    logic          full0;
    logic          full1;
    logic [3:0]    digit;
    logic [34:0]   acc_x10;
    logic [30:0]   acc_sat;
    logic [3:0]    ident_kind;
    logic [7:0]    esc_char;

    clxr_pkg::idle_lex_t    idle_a;
    clxr_pkg::idle_lex_t    idle_b;
    clxr_pkg::result_word_t r0;
    clxr_pkg::result_word_t r1;
    logic [1:0]             n;

    assign c     = word.ch;
    assign full0 = (tok_reg >= TW'(MAX_TOKENS));
    assign full1 = (tok_reg >= TW'(MAX_TOKENS - 1));

    // Decimal accumulate with saturation.
    assign digit   = 4'(c - 8'h30);
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {31'b0, digit};
    assign acc_sat = (acc_x10 > {4'b0, clxr_pkg::NUM_MAX}) ? clxr_pkg::NUM_MAX
                                                            : acc_x10[30:0];

    // Keyword kind of the identifier being finished, and escape decoding.
    assign ident_kind = (kp_reg == clxr_pkg::KW_INT)    ? clxr_pkg::KIND_INT :
                        (kp_reg == clxr_pkg::KW_RETURN) ? clxr_pkg::KIND_RET :
                                                          clxr_pkg::KIND_NAME;
    assign esc_char   = (c == "n") ? clxr_pkg::CH_LF :
                        (c == "t") ? clxr_pkg::CH_TAB : c;

    // The byte lexed from idle, either as the first or as the second result.
    assign idle_a = clxr_pkg::idle_lex(c, full0);
    assign idle_b = clxr_pkg::idle_lex(c, full1);

    // Next state and results for the byte in the input register.
    always_comb
    begin
        mode_next = mode_reg;
        kp_next   = kp_reg;
        acc_next  = acc_reg;
        dc_next   = dc_reg;
        tok_next  = tok_reg;
        r0        = '0;
        r1        = '0;
        n         = 2'd0;

        if (word.end_of_text)
        begin
            case (mode_reg)
                clxr_pkg::MODE_IDENT, clxr_pkg::MODE_NUMBER:
                begin
                    if (full0)
                    begin
                        r0 = clxr_pkg::error_result(clxr_pkg::ERR_TOO_MANY, 8'h00);
                        n  = 2'd1;
                    end
                    else
                    begin
                        r0 = (mode_reg == clxr_pkg::MODE_IDENT)
                           ? clxr_pkg::token_result(ident_kind, 31'd0)
                           : clxr_pkg::token_result(clxr_pkg::KIND_NUM, acc_reg);
                        r1 = full1
                           ? clxr_pkg::error_result(clxr_pkg::ERR_TOO_MANY, 8'h00)
                           : clxr_pkg::token_result(clxr_pkg::KIND_EOF, 31'd0);
                        n  = 2'd2;
                    end
                end
                clxr_pkg::MODE_STRING, clxr_pkg::MODE_ESCAPE:
                begin
                    r0 = clxr_pkg::error_result(clxr_pkg::ERR_UNTERMINATED, 8'h00);
                    n  = 2'd1;
                end
                clxr_pkg::MODE_SLASH:
                begin
                    r0 = clxr_pkg::error_result(clxr_pkg::ERR_UNEXPECTED, "/");
                    n  = 2'd1;
                end
                clxr_pkg::MODE_ERROR:
                begin
                    n = 2'd0;
                end
                default:
                begin
                    r0 = full0 ? clxr_pkg::error_result(clxr_pkg::ERR_TOO_MANY, 8'h00)
                               : clxr_pkg::token_result(clxr_pkg::KIND_EOF, 31'd0);
                    n  = 2'd1;
                end
            endcase
            // End of text returns everything to the reset state.
            mode_next = clxr_pkg::MODE_IDLE;
            kp_next   = clxr_pkg::KW_NONE;
            acc_next  = '0;
            dc_next   = '0;
            tok_next  = '0;
        end
        else
        begin
            case (mode_reg)
                clxr_pkg::MODE_IDENT, clxr_pkg::MODE_NUMBER:
                begin
                    if (mode_reg == clxr_pkg::MODE_IDENT && clxr_pkg::is_ident_char(c))
                    begin
                        r0      = clxr_pkg::text_result(clxr_pkg::KIND_NAME, c);
                        n       = 2'd1;
                        kp_next = clxr_pkg::kw_next(kp_reg, c);
                    end
                    else if (mode_reg == clxr_pkg::MODE_NUMBER && clxr_pkg::is_digit(c))
                    begin
                        if (dc_reg >= DW'(MAX_DIGITS))
                        begin
                            r0        = clxr_pkg::error_result(clxr_pkg::ERR_LONG_NUMBER,
                                                               8'h00);
                            n         = 2'd1;
                            mode_next = clxr_pkg::MODE_ERROR;
                        end
                        else
                        begin
                            dc_next  = dc_reg + DW'(1);
                            acc_next = acc_sat;
                        end
                    end
                    else
                    begin
                        // The token ends here; the byte is then lexed from idle.
                        kp_next  = clxr_pkg::KW_NONE;
                        acc_next = '0;
                        dc_next  = '0;
                        if (full0)
                        begin
                            r0        = clxr_pkg::error_result(clxr_pkg::ERR_TOO_MANY,
                                                               8'h00);
                            n         = 2'd1;
                            mode_next = clxr_pkg::MODE_ERROR;
                        end
                        else
                        begin
                            r0 = (mode_reg == clxr_pkg::MODE_IDENT)
                               ? clxr_pkg::token_result(ident_kind, 31'd0)
                               : clxr_pkg::token_result(clxr_pkg::KIND_NUM, acc_reg);
                            r1        = idle_b.res;
                            n         = idle_b.has ? 2'd2 : 2'd1;
                            mode_next = idle_b.mode;
                            kp_next   = idle_b.kp;
                            acc_next  = idle_b.start_num ? {27'b0, digit} : 31'd0;
                            dc_next   = idle_b.start_num ? DW'(1) : DW'(0);
                            tok_next  = tok_reg + TW'(1) + TW'(idle_b.tok_inc);
                        end
                    end
                end
                clxr_pkg::MODE_STRING:
                begin
                    if (c == "\"")
                    begin
                        n = 2'd1;
                        if (full0)
                        begin
                            r0        = clxr_pkg::error_result(clxr_pkg::ERR_TOO_MANY,
                                                               8'h00);
                            mode_next = clxr_pkg::MODE_ERROR;
                        end
                        else
                        begin
                            r0        = clxr_pkg::token_result(clxr_pkg::KIND_STR, 31'd0);
                            mode_next = clxr_pkg::MODE_IDLE;
                            tok_next  = tok_reg + TW'(1);
                        end
                    end
                    else if (c == "\\")
                    begin
                        mode_next = clxr_pkg::MODE_ESCAPE;
                    end
                    else
                    begin
                        r0 = clxr_pkg::text_result(clxr_pkg::KIND_STR, c);
                        n  = 2'd1;
                    end
                end
                clxr_pkg::MODE_ESCAPE:
                begin
                    r0        = clxr_pkg::text_result(clxr_pkg::KIND_STR, esc_char);
                    n         = 2'd1;
                    mode_next = clxr_pkg::MODE_STRING;
                end
                clxr_pkg::MODE_SLASH:
                begin
                    if (c == "/")
                    begin
                        mode_next = clxr_pkg::MODE_COMMENT;
                    end
                    else
                    begin
                        r0        = clxr_pkg::error_result(clxr_pkg::ERR_UNEXPECTED, "/");
                        n         = 2'd1;
                        mode_next = clxr_pkg::MODE_ERROR;
                    end
                end
                clxr_pkg::MODE_COMMENT:
                begin
                    if (c == clxr_pkg::CH_LF)
                    begin
                        mode_next = clxr_pkg::MODE_IDLE;
                    end
                end
                clxr_pkg::MODE_ERROR:
                begin
                    n = 2'd0;
                end
                default:
                begin
                    r0        = idle_a.res;
                    n         = idle_a.has ? 2'd1 : 2'd0;
                    mode_next = idle_a.mode;
                    kp_next   = idle_a.kp;
                    acc_next  = idle_a.start_num ? {27'b0, digit} : 31'd0;
                    dc_next   = idle_a.start_num ? DW'(1) : DW'(0);
                    tok_next  = tok_reg + TW'(idle_a.tok_inc);
                end
            endcase
            // An error clears the scan state but keeps the token count.
            if (mode_next == clxr_pkg::MODE_ERROR)
            begin
                kp_next  = clxr_pkg::KW_NONE;
                acc_next = '0;
                dc_next  = '0;
            end
        end
    end

    // Mark the final result of the byte and hand the pair to the queue.
    always_comb
    begin
        step        = '0;
        step.count  = go ? n : 2'd0;
        step.first  = r0;
        step.second = r1;
        step.first.last  = (n == 2'd1);
        step.second.last = 1'b1;
    end

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= clxr_pkg::MODE_IDLE;
            kp_reg   <= clxr_pkg::KW_NONE;
            acc_reg  <= '0;
            dc_reg   <= '0;
            tok_reg  <= '0;
        end
        else if (go)
        begin
            mode_reg <= mode_next;
            kp_reg   <= kp_next;
            acc_reg  <= acc_next;
            dc_reg   <= dc_next;
            tok_reg  <= tok_next;
        end
    end

endmodule

@@ src/clxr_queue.sv @@
// Small result queue that takes up to two words a cycle and gives out one unless the consumer stalls.
module clxr_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  clxr_pkg::step_out_t     step,
    output logic                    room,
    output logic                    result_valid,
    input  logic                    result_stall,
    output clxr_pkg::result_word_t  result_word
);

    localparam int AW = $clog2(clxr_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(clxr_pkg::QUEUE_DEPTH + 1);

    clxr_pkg::result_word_t mem_reg [clxr_pkg::QUEUE_DEPTH];
    logic [AW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          wr_ptr_inc;
    logic                   pop;

    // Space for a full pair is required before a byte may be stepped.
    assign room         = (count_reg <= CW'(clxr_pkg::QUEUE_DEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result_word  = mem_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    assign wr_ptr_inc   = wr_ptr_reg + AW'(1);

    // Pointer and fill count update.
    assign wr_ptr_next = wr_ptr_reg + AW'(step.count);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + CW'(step.count) - CW'(pop);

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (step.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= step.first;
        end
        if (step.count == 2'd2) begin
            mem_reg[wr_ptr_inc] <= step.second;
        end
    end

    // Queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/c_subset_token_lexer_unit.sv @@
// A byte accepted into the input register is lexed once the queue has room; its results then enter the queue.
// Throughput: one source byte per cycle while the queue has room; each byte gives zero, one or two result words.
// A four-entry result queue absorbs two-result bytes; input stalls while it holds over two and a byte waits.
// Reset clears the scanner to idle with zero keyword, number, digit and token counts,
// and empties the input register and the result queue.
module c_subset_token_lexer_unit #(
    parameter int MAX_TOKENS = clxr_pkg::MAX_TOKENS_DEF,
    parameter int MAX_DIGITS = clxr_pkg::MAX_DIGITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_stall,
    input  clxr_pkg::char_word_t    char_word,
    output logic                    result_valid,
    input  logic                    result_stall,
    output clxr_pkg::result_word_t  result_word
);

    clxr_pkg::char_word_t in_word_reg, in_word_next;
    logic                 in_full_reg, in_full_next;
    logic                 room;
    logic                 advance;
    logic                 accept;
    clxr_pkg::step_out_t  step;

    // The held byte moves on when the queue can take a full pair.
    assign advance    = in_full_reg && room;
    assign char_stall = in_full_reg && !room;
    assign accept     = char_valid && !char_stall;

    assign in_full_next = accept || (in_full_reg && !advance);
    assign in_word_next = accept ? char_word : in_word_reg;

    // Input register.
    always_ff @(posedge clk)
    begin
        in_word_reg <= in_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg <= 1'b0;
        end
        else begin
            in_full_reg <= in_full_next;
        end
    end

    // Lexer step and scanner state.
    clxr_core #(
        .MAX_TOKENS (MAX_TOKENS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (advance),
        .word  (in_word_reg),
        .step  (step)
    );

    // Result queue toward the consumer.
    clxr_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

endmodule

@@ tb/clxr_token_checker.sv @@
// Checker for the C subset token lexer: predicts result words and compares them.
module clxr_token_checker #(
    parameter int MAX_TOKENS = clxr_pkg::MAX_TOKENS_DEF,
    parameter int MAX_DIGITS = clxr_pkg::MAX_DIGITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    input  logic                   char_stall,
    input  clxr_pkg::char_word_t   char_word,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  clxr_pkg::result_word_t result_word,
    output int                     fail_count,
    output int                     pending
);

    // Scanner state as the lexer should hold it.
    logic [2:0]   scan_state;
    logic [3:0]   kw_state;
    logic [30:0]  num_acc;
    int           digit_cnt;
    int           token_cnt;

    // Words caused by the byte being lexed, and words still owed by the block.
    clxr_pkg::result_word_t byte_words[2];
    int                     byte_word_cnt;
    clxr_pkg::result_word_t due_words[$];
    clxr_pkg::result_word_t oldest;

    function automatic clxr_pkg::result_word_t make_word(
        input logic [1:0] rtype, input logic [3:0] kind, input logic [30:0] value,
        input logic [7:0] chr, input logic [1:0] code, input logic [7:0] bad);
        clxr_pkg::result_word_t w;
        w.result_type  = rtype;
        w.token_kind   = kind;
        w.number_value = value;
        w.text_char    = chr;
        w.error_code   = code;
        w.bad_char     = bad;
        w.last         = 1'b0;
        return w;
    endfunction

    // A byte never causes more than two words; anything past that is dropped.
    function automatic void add_word(input clxr_pkg::result_word_t w);
        if (byte_word_cnt < 2)
        begin
            byte_words[byte_word_cnt] = w;
            byte_word_cnt++;
        end
    endfunction

    function automatic void clear_scan();
        scan_state = clxr_pkg::MODE_IDLE;
        kw_state   = clxr_pkg::KW_NONE;
        num_acc    = '0;
        digit_cnt  = 0;
        token_cnt  = 0;
    endfunction

    // An error parks the scanner until the next end of text.
    function automatic void raise_fault(input logic [1:0] code, input logic [7:0] bad);
        add_word(make_word(clxr_pkg::RT_ERROR, clxr_pkg::KIND_EOF, '0, '0, code, bad));
        scan_state = clxr_pkg::MODE_ERROR;
        kw_state   = clxr_pkg::KW_NONE;
        num_acc    = '0;
        digit_cnt  = 0;
    endfunction

    // Emit a token unless the budget is spent, in which case it becomes an error.
    function automatic bit emit_token(input logic [3:0] kind, input logic [30:0] value);
        if (token_cnt >= MAX_TOKENS)
        begin
            raise_fault(clxr_pkg::ERR_TOO_MANY, 8'h00);
            return 1'b0;
        end
        add_word(make_word(clxr_pkg::RT_TOKEN, kind, value, '0, '0, '0));
        token_cnt++;
        scan_state = clxr_pkg::MODE_IDLE;
        return 1'b1;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_name_char(input logic [7:0] c);
        return is_letter(c) || is_numeral(c) || c == "_";
    endfunction

    // Track how far the identifier so far matches "int" or "return".
    function automatic logic [3:0] advance_kw(input logic [3:0] kp, input logic [7:0] c);
        case (kp)
            clxr_pkg::KW_I:
                return (c == "n") ? clxr_pkg::KW_IN : clxr_pkg::KW_NONE;
            clxr_pkg::KW_IN:
                return (c == "t") ? clxr_pkg::KW_INT : clxr_pkg::KW_NONE;
            clxr_pkg::KW_R:
                return (c == "e") ? clxr_pkg::KW_RE : clxr_pkg::KW_NONE;
            clxr_pkg::KW_RE:
                return (c == "t") ? clxr_pkg::KW_RET : clxr_pkg::KW_NONE;
            clxr_pkg::KW_RET:
                return (c == "u") ? clxr_pkg::KW_RETU : clxr_pkg::KW_NONE;
            clxr_pkg::KW_RETU:
                return (c == "r") ? clxr_pkg::KW_RETUR : clxr_pkg::KW_NONE;
            clxr_pkg::KW_RETUR:
                return (c == "n") ? clxr_pkg::KW_RETURN : clxr_pkg::KW_NONE;
            default:
                return clxr_pkg::KW_NONE;
        endcase
    endfunction

    function automatic bit close_ident();
        logic [3:0] kind;
        kind = clxr_pkg::KIND_NAME;
        if (kw_state == clxr_pkg::KW_INT)
            kind = clxr_pkg::KIND_INT;
        else if (kw_state == clxr_pkg::KW_RETURN)
            kind = clxr_pkg::KIND_RET;
        kw_state = clxr_pkg::KW_NONE;
        return emit_token(kind, '0);
    endfunction

    function automatic bit close_number();
        logic [30:0] value;
        value     = num_acc;
        num_acc   = '0;
        digit_cnt = 0;
        return emit_token(clxr_pkg::KIND_NUM, value);
    endfunction

    // Lex one byte as the start of a new token.
    function automatic void start_token(input logic [7:0] c);
        scan_state = clxr_pkg::MODE_IDLE;
        if (c == " " || (c >= clxr_pkg::CH_TAB && c <= 8'h0D))
        begin
            scan_state = clxr_pkg::MODE_IDLE;
        end
        else if (c == "/")
        begin
            scan_state = clxr_pkg::MODE_SLASH;
        end
        else if (c == "\"")
        begin
            scan_state = clxr_pkg::MODE_STRING;
        end
        else if (is_letter(c) || c == "_")
        begin
            scan_state = clxr_pkg::MODE_IDENT;
            kw_state   = (c == "i") ? clxr_pkg::KW_I :
                         (c == "r") ? clxr_pkg::KW_R : clxr_pkg::KW_NONE;
            add_word(make_word(clxr_pkg::RT_TEXT, clxr_pkg::KIND_NAME, '0, c, '0, '0));
        end
        else if (is_numeral(c))
        begin
            scan_state = clxr_pkg::MODE_NUMBER;
            num_acc    = 31'(c - "0");
            digit_cnt  = 1;
        end
        else
        begin
            case (c)
                "(":     void'(emit_token(clxr_pkg::KIND_OPEN_PAREN, '0));
                ")":     void'(emit_token(clxr_pkg::KIND_CLOSE_PAREN, '0));
                "{":     void'(emit_token(clxr_pkg::KIND_OPEN_BRACE, '0));
                "}":     void'(emit_token(clxr_pkg::KIND_CLOSE_BRACE, '0));
                ";":     void'(emit_token(clxr_pkg::KIND_SEMI, '0));
                ",":     void'(emit_token(clxr_pkg::KIND_SEPARATOR, '0));
                default: raise_fault(clxr_pkg::ERR_UNEXPECTED, c);
            endcase
        end
    endfunction

    // End of text closes a name or number, adds end of file or reports a fault.
    function automatic void finish_text();
        case (scan_state)
            clxr_pkg::MODE_IDENT:
            begin
                if (close_ident())
                    void'(emit_token(clxr_pkg::KIND_EOF, '0));
            end
            clxr_pkg::MODE_NUMBER:
            begin
                if (close_number())
                    void'(emit_token(clxr_pkg::KIND_EOF, '0));
            end
            clxr_pkg::MODE_STRING, clxr_pkg::MODE_ESCAPE:
                raise_fault(clxr_pkg::ERR_UNTERMINATED, 8'h00);
            clxr_pkg::MODE_SLASH:
                raise_fault(clxr_pkg::ERR_UNEXPECTED, "/");
            clxr_pkg::MODE_ERROR:
            begin
            end
            default:
                void'(emit_token(clxr_pkg::KIND_EOF, '0));
        endcase
    endfunction

    // Work out the words caused by one accepted source word.
    function automatic void lex_byte(input clxr_pkg::char_word_t w);
        logic [7:0]      c;
        longint unsigned grown;
        c             = w.ch;
        byte_word_cnt = 0;
        if (w.end_of_text)
        begin
            finish_text();
            clear_scan();
        end
        else
        begin
            case (scan_state)
                clxr_pkg::MODE_IDENT:
                begin
                    if (is_name_char(c))
                    begin
                        add_word(make_word(clxr_pkg::RT_TEXT, clxr_pkg::KIND_NAME, '0, c,
                                           '0, '0));
                        kw_state = advance_kw(kw_state, c);
                    end
                    else if (close_ident())
                    begin
                        start_token(c);
                    end
                end
                clxr_pkg::MODE_NUMBER:
                begin
                    if (is_numeral(c))
                    begin
                        if (digit_cnt >= MAX_DIGITS)
                        begin
                            raise_fault(clxr_pkg::ERR_LONG_NUMBER, 8'h00);
                        end
                        else
                        begin
                            digit_cnt++;
                            grown   = num_acc * 64'd10 + 64'(c - "0");
                            num_acc = (grown > clxr_pkg::NUM_MAX) ? clxr_pkg::NUM_MAX
                                                                  : grown[30:0];
                        end
                    end
                    else if (close_number())
                    begin
                        start_token(c);
                    end
                end
                clxr_pkg::MODE_STRING:
                begin
                    if (c == "\"")
                        void'(emit_token(clxr_pkg::KIND_STR, '0));
                    else if (c == "\\")
                        scan_state = clxr_pkg::MODE_ESCAPE;
                    else
                        add_word(make_word(clxr_pkg::RT_TEXT, clxr_pkg::KIND_STR, '0, c,
                                           '0, '0));
                end
                clxr_pkg::MODE_ESCAPE:
                begin
                    add_word(make_word(clxr_pkg::RT_TEXT, clxr_pkg::KIND_STR, '0,
                                       (c == "n") ? clxr_pkg::CH_LF :
                                       (c == "t") ? clxr_pkg::CH_TAB : c, '0, '0));
                    scan_state = clxr_pkg::MODE_STRING;
                end
                clxr_pkg::MODE_SLASH:
                begin
                    if (c == "/")
                        scan_state = clxr_pkg::MODE_COMMENT;
                    else
                        raise_fault(clxr_pkg::ERR_UNEXPECTED, "/");
                end
                clxr_pkg::MODE_COMMENT:
                begin
                    if (c == clxr_pkg::CH_LF)
                        scan_state = clxr_pkg::MODE_IDLE;
                end
                clxr_pkg::MODE_ERROR:
                begin
                end
                default:
                    start_token(c);
            endcase
        end
        if (byte_word_cnt > 0)
            byte_words[byte_word_cnt - 1].last = 1'b1;
        for (int i = 0; i < byte_word_cnt; i++)
            due_words.push_back(byte_words[i]);
    endfunction

    function automatic void check_field(input string name, input logic [30:0] want,
                                        input logic [30:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Predict on every accepted source word and check every accepted result word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            due_words.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (char_valid && !char_stall)
                lex_byte(char_word);
            if (result_valid && !result_stall)
            begin
                if (due_words.size() == 0)
                begin
                    $error("result word with no expected word waiting: type %0d kind %0d",
                           result_word.result_type, result_word.token_kind);
                    fail_count++;
                end
                else
                begin
                    oldest = due_words.pop_front();
                    check_field("result_type", oldest.result_type, result_word.result_type);
                    check_field("token_kind", oldest.token_kind, result_word.token_kind);
                    check_field("number_value", oldest.number_value, result_word.number_value);
                    check_field("text_char", oldest.text_char, result_word.text_char);
                    check_field("error_code", oldest.error_code, result_word.error_code);
                    check_field("bad_char", oldest.bad_char, result_word.bad_char);
                    check_field("last", oldest.last, result_word.last);
                end
            end
            pending = due_words.size();
        end
    end

endmodule

@@ tb/tb_c_subset_token_lexer_unit.sv @@
// Testbench top for the C subset token lexer: source text stimulus and the verdict.
module tb_c_subset_token_lexer_unit;

    // A small token budget so that the token limit is reached by ordinary texts.
    localparam int TOKEN_BUDGET = 40;
    localparam int DIGIT_LIMIT  = clxr_pkg::MAX_DIGITS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   char_valid   = 1'b0;
    logic                   char_stall;
    clxr_pkg::char_word_t   char_word    = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    clxr_pkg::result_word_t result_word;

    int           fail_count;
    int           pending;
    int           cycle_count  = 0;
    int           words_sent   = 0;
    int           gap_odds     = 10;
    bit           idle_on      = 1'b1;
    bit           hold_req     = 1'b0;
    bit           hold_done    = 1'b0;
    logic [7:0]   src_text[$];

    c_subset_token_lexer_unit #(
        .MAX_TOKENS (TOKEN_BUDGET),
        .MAX_DIGITS (DIGIT_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_word    (char_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    clxr_token_checker #(
        .MAX_TOKENS (TOKEN_BUDGET),
        .MAX_DIGITS (DIGIT_LIMIT)
    ) token_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_word    (char_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog on the whole run.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off that fills the block.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                result_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Offer one source word and wait until the block takes it.
    task automatic send_word(input logic [7:0] c, input logic eot);
        if (idle_on && gap_odds > 0 && $urandom_range(1, gap_odds) == 1)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        char_word  <= '{ch: c, end_of_text: eot};
        char_valid <= 1'b1;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            src_text.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_name_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r < 62)
            return 8'("0" + r - 52);
        return "_";
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // Identifiers: keywords, near misses of keywords, and random names.
    function automatic void add_ident();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
        begin
            put_str("int");
        end
        else if (r == 1)
        begin
            put_str("return");
        end
        else if (r == 2)
        begin
            case ($urandom_range(0, 5))
                0:       put_str("in");
                1:       put_str("intx");
                2:       put_str("retur");
                3:       put_str("returns");
                4:       put_str("r_t");
                default: put_str("i");
            endcase
        end
        else
        begin
            r = $urandom_range(0, 52);
            src_text.push_back((r < 26) ? 8'("a" + r) : (r < 52) ? 8'("A" + r - 26) : "_");
            repeat ($urandom_range(0, 8))
                src_text.push_back(rand_name_char());
        end
    endfunction

    // Numbers: mostly short, some that saturate, a few at or over the digit limit.
    function automatic void add_number();
        int r;
        int n;
        r = $urandom_range(0, 49);
        if (r < 2)
            n = DIGIT_LIMIT + 1 + $urandom_range(0, 2);
        else if (r < 4)
            n = DIGIT_LIMIT;
        else if (r < 10)
            n = $urandom_range(10, 12);
        else
            n = $urandom_range(1, 5);
        repeat (n)
            src_text.push_back(rand_digit());
    endfunction

    function automatic void add_string_char();
        logic [7:0] c;
        if ($urandom_range(0, 4) == 0)
        begin
            src_text.push_back("\\");
            case ($urandom_range(0, 4))
                0:       src_text.push_back("n");
                1:       src_text.push_back("t");
                2:       src_text.push_back("\"");
                3:       src_text.push_back("\\");
                default: src_text.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        else
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == "\"" || c == "\\");
            src_text.push_back(c);
        end
    endfunction

    function automatic void add_space();
        int r;
        r = $urandom_range(0, 5);
        src_text.push_back((r == 0) ? " " : 8'(clxr_pkg::CH_TAB + r - 1));
    endfunction

    // One random token, or now and then a stray byte.
    function automatic void add_lexeme(input bit allow_noise);
        logic [7:0] c;
        int         r;
        r = $urandom_range(0, 39);
        if (r < 10)
        begin
            add_ident();
        end
        else if (r < 19)
        begin
            add_number();
        end
        else if (r < 28)
        begin
            case ($urandom_range(0, 5))
                0:       src_text.push_back("(");
                1:       src_text.push_back(")");
                2:       src_text.push_back("{");
                3:       src_text.push_back("}");
                4:       src_text.push_back(";");
                default: src_text.push_back(",");
            endcase
        end
        else if (r < 33)
        begin
            src_text.push_back("\"");
            repeat ($urandom_range(0, 8))
                add_string_char();
            src_text.push_back("\"");
        end
        else if (r < 36)
        begin
            put_str("//");
            repeat ($urandom_range(0, 6))
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == clxr_pkg::CH_LF);
                src_text.push_back(c);
            end
            src_text.push_back(clxr_pkg::CH_LF);
        end
        else if (r < 39 || !allow_noise)
        begin
            add_space();
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            src_text.push_back("/");
        end
        else
        begin
            src_text.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Build one source text of random tokens, with a random ending, and send it.
    task automatic send_text();
        int n_tokens;
        bit long_text;
        src_text.delete();
        long_text = ($urandom_range(0, 5) == 0);
        n_tokens  = long_text ? $urandom_range(35, 50) : $urandom_range(1, 20);
        gap_odds  = ($urandom_range(0, 2) == 0) ? 0 : 10;
        repeat (n_tokens)
        begin
            add_lexeme(!long_text);
            if ($urandom_range(0, 1) == 0)
                add_space();
        end
        case ($urandom_range(0, 11))
            0:
            begin
                src_text.push_back("\"");
                repeat ($urandom_range(0, 3))
                    add_string_char();
                if ($urandom_range(0, 1) == 0)
                    src_text.push_back("\\");
            end
            1:       src_text.push_back("/");
            2:       put_str("// tail");
            default:
            begin
            end
        endcase
        foreach (src_text[i])
            send_word(src_text[i], 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Main sequence: directed texts, random texts with a long hold-off, then no idling.
    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Keywords, punctuation ending tokens, a number and string escapes.
        send_chars("int(return)7,\"\\n\\q\"");
        send_word(8'h00, 1'b1);
        // A lone slash at end of text, then a byte with all bits set.
        send_chars("/");
        send_word(8'hA5, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h5A, 1'b1);

        while (words_sent < 500)
            send_text();
        hold_req = 1'b1;
        while (words_sent < 1000)
            send_text();
        idle_on = 1'b0;
        while (words_sent < 1150)
            send_text();
        char_valid <= 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
src/clxr_pkg.sv
src/clxr_core.sv
src/clxr_queue.sv
src/c_subset_token_lexer_unit.sv
tb/clxr_token_checker.sv
tb/tb_c_subset_token_lexer_unit.sv
